// ===== design/gbt_pkg.sv =====
// Shared types and constants for the graph traversal block.
`default_nettype none
package gbt_pkg;
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_LABEL = 3'd1;
  localparam logic [2:0] OP_EDGE  = 3'd2;
  localparam logic [2:0] OP_BFS   = 3'd3;
  localparam logic [2:0] OP_DFS   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
    logic [7:0] label_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0] visited_vertex;
    logic [7:0] visited_label;
    logic       last;
    logic [1:0] status;
  } out_item_t;
endpackage
`default_nettype wire

// ===== design/gbt_in_if.sv =====
// Valid/ready channel carrying one operation item.
`default_nettype none
interface gbt_in_if;
  import gbt_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/gbt_out_if.sv =====
// Valid/ready channel carrying one result item.
`default_nettype none
interface gbt_out_if;
  import gbt_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/gbt_out_reg.sv =====
// Two-entry output buffer decoupling the engine from the result receiver.
`default_nettype none
module gbt_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire gbt_pkg::out_item_t push_data,
  output logic                   full,
  output logic                   empty,
  gbt_out_if.source              out_ch
);
  import gbt_pkg::*;
  out_item_t buf_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  logic       pop;

  assign pop = out_ch.valid & out_ch.ready;
  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.payload = buf_r[rd_r];
  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_r] <= push_data;
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== design/gbt_engine.sv =====
// Sequencer that holds the graph in block memories and walks it.
`default_nettype none
module gbt_engine #(
  parameter int MAX_VERTICES   = 64,
  parameter int MAX_EDGE_NODES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [6:0]         cfg_count,
  input  wire logic               in_valid,
  input  wire gbt_pkg::in_item_t  in_data,
  output logic                    in_ready,
  output logic                    res_push,
  output gbt_pkg::out_item_t      res_data,
  input  wire logic               res_full,
  input  wire logic               res_empty
);
  import gbt_pkg::*;
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_EDGE_NODES);
  localparam int UW = NW + 1;

  localparam logic [3:0] S_RST   = 4'd0,  S_IDLE  = 4'd1,  S_CLR   = 4'd2,
                         S_LWR   = 4'd3,  S_EAPP  = 4'd4,  S_ELNK  = 4'd5,
                         S_OUT   = 4'd6,  S_SCAN  = 4'd7,  S_SRD   = 4'd8,
                         S_POP   = 4'd9,  S_PRD   = 4'd10, S_NRD   = 4'd11,
                         S_NCHK  = 4'd12, S_VEMIT = 4'd13;

  // vertex memory: label, head, tail, filled
  localparam int VMW = 8 + NW + NW + 1;
  logic [VMW-1:0] vmem [MAX_VERTICES];
  logic [VMW-1:0] vrd_r;
  logic [VW-1:0]  vaddr;
  logic           vwe;
  logic [VMW-1:0] vwd;
  // node memory: target, next
  logic [VW+NW-1:0] nmem [MAX_EDGE_NODES];
  logic [VW+NW-1:0] nrd_r;
  logic [NW-1:0]    naddr, nwaddr;
  logic             nwe, nlink;
  logic [VW+NW-1:0] nwd;
  // queue/stack memory: vertex, node, tail, live
  localparam int WMW = VW + NW + NW + 1;
  logic [WMW-1:0] wmem [MAX_VERTICES];
  logic [WMW-1:0] wrd_r;
  logic [VW-1:0]  wraddr, wwaddr;
  logic           wwe;
  logic [WMW-1:0] wwd;
  logic [MAX_VERTICES-1:0] vis_r;

  logic [3:0]    st_r;
  logic [7:0]    lab_r;
  logic [UW-1:0] used_r;
  logic [VW:0]   n_r, emit_r, qh_r, qt_r;
  logic [VW-1:0] scan_r, clr_r, cur_r, tgt_r;
  logic [NW-1:0] p_r, tail_r;
  logic [1:0]    stat_r;
  logic          dfs_r, link_r, second_r, endl_r;
  logic [VW:0]   ncnt;
  logic          emit_last;

  always_ff @(posedge clk) begin
    if (vwe) vmem[vaddr] <= vwd;
    vrd_r <= vmem[vaddr];
    if (nwe) begin
      if (nlink) nmem[nwaddr][NW-1:0] <= nwd[NW-1:0];
      else nmem[nwaddr] <= nwd;
    end
    nrd_r <= nmem[naddr];
    if (wwe) wmem[wwaddr] <= wwd;
    wrd_r <= wmem[wraddr];
  end

  always_comb begin
    if (cfg_count == 7'd0) ncnt = (VW+1)'(1);
    else if ({25'd0, cfg_count} > MAX_VERTICES) ncnt = (VW+1)'(MAX_VERTICES);
    else ncnt = (VW+1)'(cfg_count);
  end

  wire [7:0]    v_lab  = vrd_r[VMW-1 -: 8];
  wire [NW-1:0] v_head = vrd_r[NW+NW:NW+1];
  wire [NW-1:0] v_tail = vrd_r[NW:1];
  wire          v_fill = vrd_r[0];
  wire [VW-1:0] n_tgt  = nrd_r[VW+NW-1:NW];
  wire [NW-1:0] n_next = nrd_r[NW-1:0];
  wire [VW-1:0] ia = in_data.vertex_a[VW-1:0];
  wire [VW-1:0] ib = in_data.vertex_b[VW-1:0];
  wire          a_bad = {1'b0, in_data.vertex_a} >= 7'(ncnt);
  wire          b_bad = {1'b0, in_data.vertex_b} >= 7'(ncnt);

  assign emit_last = (emit_r + 1'b1 == n_r);

  always_comb begin
    vaddr = cur_r; vwe = 1'b0; vwd = '0;
    naddr = p_r; nwaddr = used_r[NW-1:0]; nwe = 1'b0; nlink = 1'b0; nwd = '0;
    wraddr = qh_r[VW-1:0]; wwaddr = qt_r[VW-1:0]; wwe = 1'b0; wwd = '0;
    in_ready = (st_r == S_IDLE) && res_empty;
    res_push = 1'b0;
    res_data = '0;
    unique case (st_r)
      S_RST, S_CLR: begin
        vaddr = clr_r; vwe = 1'b1;
      end
      S_IDLE: vaddr = ia;
      S_LWR: begin
        vwe = 1'b1; vwd = {lab_r, vrd_r[VMW-9:0]};
      end
      S_EAPP: begin
        nwe = 1'b1; nwd = {tgt_r, {NW{1'b0}}};
        vwe = 1'b1;
        vwd = {v_lab, (v_fill ? v_head : used_r[NW-1:0]), used_r[NW-1:0], 1'b1};
      end
      S_ELNK: begin
        // link the old tail to the new node; fetch the other endpoint
        vaddr = tgt_r;
        nwe = link_r; nlink = 1'b1; nwaddr = tail_r;
        nwd = {{VW{1'b0}}, used_r[NW-1:0]};
      end
      S_OUT: begin
        res_push = !res_full;
        res_data.last = 1'b1;
        res_data.status = stat_r;
      end
      S_SCAN: vaddr = scan_r;
      S_SRD: begin
        vaddr = scan_r;
        if (!res_full) begin
          res_push = 1'b1;
          res_data.visited_vertex = 6'(scan_r);
          res_data.visited_label = v_lab;
          res_data.last = emit_last;
          wwe = 1'b1; wwd = {scan_r, v_head, v_tail, v_fill};
        end
      end
      S_POP: wraddr = dfs_r ? VW'(qt_r - 1'b1) : qh_r[VW-1:0];
      S_PRD, S_NRD: ;
      S_NCHK: begin
        vaddr = n_tgt;
        // advance the stack top past this node
        if (dfs_r) begin
          wwe = 1'b1; wwaddr = VW'(qt_r - 1'b1);
          wwd = {cur_r, n_next, tail_r, (p_r != tail_r)};
        end
      end
      S_VEMIT: begin
        vaddr = tgt_r;
        if (!res_full) begin
          res_push = 1'b1;
          res_data.visited_vertex = 6'(tgt_r);
          res_data.visited_label = v_lab;
          res_data.last = emit_last;
          wwe = 1'b1; wwd = {tgt_r, v_head, v_tail, v_fill};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_RST; lab_r <= '0; used_r <= '0; clr_r <= '0; vis_r <= '0;
      emit_r <= '0; qh_r <= '0; qt_r <= '0; scan_r <= '0; n_r <= '0;
      stat_r <= ST_OK; dfs_r <= 1'b0; cur_r <= '0; tgt_r <= '0; p_r <= '0;
      tail_r <= '0; link_r <= 1'b0; second_r <= 1'b0; endl_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_RST, S_CLR:
          if (clr_r == VW'(MAX_VERTICES - 1)) begin
            st_r <= (st_r == S_CLR) ? S_OUT : S_IDLE;
          end else clr_r <= clr_r + 1'b1;
        S_IDLE: if (in_valid && in_ready) begin
          lab_r <= in_data.label_value; stat_r <= ST_OK; n_r <= ncnt;
          unique case (in_data.operation)
            OP_CLEAR: begin clr_r <= '0; used_r <= '0; st_r <= S_CLR; end
            OP_LABEL:
              if (a_bad) begin
                stat_r <= ST_INDEX; st_r <= S_OUT;
              end else begin cur_r <= ia; st_r <= S_LWR; end
            OP_EDGE:
              if (a_bad || b_bad) begin
                stat_r <= ST_INDEX; st_r <= S_OUT;
              end else if (32'(used_r) + 2 > MAX_EDGE_NODES) begin
                stat_r <= ST_FULL; st_r <= S_OUT;
              end else begin
                cur_r <= ia; tgt_r <= ib; second_r <= 1'b0; st_r <= S_EAPP;
              end
            OP_BFS, OP_DFS: begin
              vis_r <= '0; scan_r <= '0; emit_r <= '0; qh_r <= '0; qt_r <= '0;
              dfs_r <= (in_data.operation == OP_DFS); st_r <= S_SCAN;
            end
            default: st_r <= S_OUT;
          endcase
        end
        S_LWR: st_r <= S_OUT;
        S_EAPP: begin
          tail_r <= v_tail; link_r <= v_fill; st_r <= S_ELNK;
        end
        S_ELNK: begin
          used_r <= used_r + 1'b1;
          if (second_r) st_r <= S_OUT;
          else begin
            second_r <= 1'b1; cur_r <= tgt_r; tgt_r <= cur_r; st_r <= S_EAPP;
          end
        end
        S_OUT: if (!res_full) st_r <= S_IDLE;
        S_SCAN:
          if (vis_r[scan_r]) scan_r <= scan_r + 1'b1;
          else st_r <= S_SRD;
        S_SRD: if (!res_full) begin
          vis_r[scan_r] <= 1'b1; emit_r <= emit_r + 1'b1; qt_r <= qt_r + 1'b1;
          st_r <= emit_last ? S_IDLE : S_POP;
        end
        S_POP:
          if (dfs_r ? (qt_r == '0) : (qh_r == qt_r)) begin
            scan_r <= scan_r + 1'b1; st_r <= S_SCAN;
          end else st_r <= S_PRD;
        S_PRD: begin
          cur_r <= wrd_r[WMW-1 -: VW]; p_r <= wrd_r[NW+NW:NW+1]; tail_r <= wrd_r[NW:1];
          if (!dfs_r) qh_r <= qh_r + 1'b1;
          if (!wrd_r[0]) begin
            // drop an exhausted stack entry
            if (dfs_r) qt_r <= qt_r - 1'b1;
            st_r <= S_POP;
          end else st_r <= S_NRD;
        end
        S_NRD: st_r <= S_NCHK;
        S_NCHK:
          if ({1'b0, n_tgt} < n_r && !vis_r[n_tgt]) begin
            tgt_r <= n_tgt; endl_r <= (p_r == tail_r); p_r <= n_next; st_r <= S_VEMIT;
          end else if (!dfs_r && p_r != tail_r) begin
            p_r <= n_next; st_r <= S_NRD;
          end else st_r <= S_POP;
        S_VEMIT: if (!res_full) begin
          vis_r[tgt_r] <= 1'b1; emit_r <= emit_r + 1'b1; qt_r <= qt_r + 1'b1;
          if (emit_last) st_r <= S_IDLE;
          else if (!dfs_r && !endl_r) st_r <= S_NRD;
          else st_r <= S_POP;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/graph_bfs_dfs_traversal.sv =====
// Graph store with breadth-first and depth-first traversal: top level.
// Channels: in_ch carries one operation item (clear, set label, add edge,
// breadth-first, depth-first); out_ch returns result items, the final one
// of each item flagged by last. cfg_we/cfg_wdata write vertex_count.
// Items are taken one at a time: in_ch is ready only when the engine is idle
// and every result of the previous item has left the output buffer.
// After accept: an error or unused op goes straight to its result; set label
// does a read-modify-write of the vertex row; add edge makes two appends of a
// node write plus a tail link each; clear zeroes the vertex rows (one vertex
// row zeroed per cycle).
// Traversals emit vertex_count results. Each restart vertex is found by
// scanning past visited indices; breadth-first dequeues each vertex and
// examines its edge nodes, depth-first resumes from the stack top at each
// edge node examined, and each unvisited neighbor found is emitted.
// After reset the vertex memory is cleared, and no item is accepted until
// that is done. A stalled receiver holds results in a two-entry buffer and
// the engine waits while that buffer is full.
`default_nettype none
module graph_bfs_dfs_traversal #(
  parameter int MAX_VERTICES   = 64,
  parameter int MAX_EDGE_NODES = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  gbt_in_if.sink          in_ch,
  gbt_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata
);
  import gbt_pkg::*;
  logic [6:0] count_r;
  logic       push, full, empty;
  out_item_t  pdata;

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= 7'd1;
    else if (cfg_we) count_r <= cfg_wdata;
  end

  gbt_engine #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGE_NODES(MAX_EDGE_NODES)) u_eng (
    .clk, .rst_n, .cfg_count(count_r), .in_valid(in_ch.valid), .in_data(in_ch.payload),
    .in_ready(in_ch.ready), .res_push(push), .res_data(pdata), .res_full(full),
    .res_empty(empty)
  );

  gbt_out_reg u_out (
    .clk, .rst_n, .push, .push_data(pdata), .full, .empty, .out_ch
  );
endmodule
`default_nettype wire

// ===== design/gbt_checker.sv =====
// Port-level checks for the graph traversal block, bound to the top level.
`default_nettype none
module gbt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last,
  input wire logic [1:0] out_status
);
  import gbt_pkg::*;
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_FULL) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
  a_nlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last) else $error("error not last");
endmodule

bind graph_bfs_dfs_traversal gbt_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.payload.last), .out_status(out_ch.payload.status)
);
`default_nettype wire
